FILE: hw/rtl/asfc_pkg.sv
// Alert string format checker: shared types, character codes and status codes.
// No dependencies; used by every other file of the block.
package asfc_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned LenW   = 6;
  localparam int unsigned CntW   = 3;
  localparam int unsigned StatW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 6;

  localparam logic [ChW-1:0] ChSep   = 8'h7C;  // '|'
  localparam logic [ChW-1:0] ChClose = 8'h5D;  // ']'
  localparam logic [ChW-1:0] ChOpen  = 8'h5B;  // '['
  localparam logic [ChW-1:0] ChDigLo = 8'h30;  // '0'
  localparam logic [ChW-1:0] ChDigHi = 8'h33;  // '3'

  localparam logic [LenW-1:0] RstMaxTextLen   = 6'd30;
  localparam logic [CntW-1:0] RstMaxTextLines = 3'd5;
  localparam logic [LenW-1:0] RstMaxButtonLen = 6'd10;
  localparam logic [CntW-1:0] RstMaxButtons   = 3'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxTextLen   = 2'd0,
    CfgMaxTextLines = 2'd1,
    CfgMaxButtonLen = 2'd2,
    CfgMaxButtons   = 2'd3
  } cfg_idx_e;

  typedef enum logic [StatW-1:0] {
    StOk           = 4'd0,
    StIcon         = 4'd1,
    StTextLong     = 4'd2,
    StTextLines    = 4'd3,
    StTextOpen     = 4'd4,
    StTextEmpty    = 4'd5,
    StNoBracket    = 4'd6,
    StButtonLong   = 4'd7,
    StButtonsMany  = 4'd8,
    StButtonsOpen  = 4'd9,
    StButtonsEmpty = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    PhIcon    = 2'd0,
    PhText    = 2'd1,
    PhBopen   = 2'd2,
    PhButtons = 2'd3
  } phase_e;

  typedef struct packed {
    logic [LenW-1:0] max_text_len;
    logic [CntW-1:0] max_text_lines;
    logic [LenW-1:0] max_button_len;
    logic [CntW-1:0] max_buttons;
  } cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [1:0]      icon_pos;
    logic [LenW-1:0] field_chars;
    logic [CntW-1:0] field_count;
    logic            any_chars;
    status_e         verdict;
    logic            settled;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    phase:       PhIcon,
    icon_pos:    2'd0,
    field_chars: '0,
    field_count: '0,
    any_chars:   1'b0,
    verdict:     StOk,
    settled:     1'b0
  };

endpackage

FILE: hw/rtl/asfc_if.sv
// Stream interfaces of the alert string format checker: character in, status out.
// Depends on asfc_pkg for field widths.
interface asfc_char_if;
  logic                       valid;
  logic                       ready;
  logic [asfc_pkg::ChW-1:0]   ch;
  logic                       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface asfc_status_if;
  logic                       valid;
  logic                       ready;
  logic [asfc_pkg::StatW-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

FILE: hw/rtl/alert_string_format_checker_unit.sv
// Alert string format checker, top level: input register, scan state, status register.
// Depends on asfc_pkg, asfc_if, asfc_cfg_regs and asfc_step.
// Usage:
//   char_in carries one character beat per cycle while ready is high (ch, last).
//   The string is "[d]" with d in '0'..'3', one unchecked character as text opener,
//   a text section closed by ']' and a bracketed button section, fields split by '|'.
//   status_out carries one beat per string, on the beat marked last; other
//   characters produce nothing.
//   Limits are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
// Timing:
//   One character per cycle sustained while the status register can take each last
//   beat. A character is held in the input register and scanned by asfc_step; a
//   last one loads the status register once that is free, and status_out is then
//   valid until taken. The state register is the only loop.
// Reset: limits go to 30/5/10/3, scan state to the icon phase, both stages
//   empty. After each last beat the scan state returns to the icon phase.
// Stall: a status beat waits in its register while status_out.ready is low;
//   non-last characters still flow, a last one waits in the input register,
//   and char_in.ready drops only when both registers are full.
module alert_string_format_checker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [asfc_pkg::CfgDataW-1:0] cfg_wdata_i,
  asfc_char_if.sink                     char_in,
  asfc_status_if.source                 status_out
);

  asfc_pkg::cfg_t cfg;

  asfc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // input register
  logic                       s1_valid_q;
  logic [asfc_pkg::ChW-1:0]   s1_ch_q;
  logic                       s1_last_q;

  // scan state and result register
  asfc_pkg::scan_state_t      state_q, state_d;
  logic                       out_valid_q;
  logic [asfc_pkg::StatW-1:0] out_status_q, status_d;

  logic out_free;
  logic s1_fire;
  logic in_ready;

  asfc_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .ch_i    (s1_ch_q),
    .last_i  (s1_last_q),
    .state_o (state_d),
    .status_o(status_d)
  );

  // A non-last character never needs the result slot, so only last beats stall.
  assign out_free = !out_valid_q || status_out.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready = !s1_valid_q || s1_fire;

  assign char_in.ready     = in_ready;
  assign status_out.valid  = out_valid_q;
  assign status_out.status = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= asfc_pkg::ScanReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= char_in.valid;
      end
      if (s1_fire) begin
        state_q <= s1_last_q ? asfc_pkg::ScanReset : state_d;
      end
      if (s1_fire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (status_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready && char_in.valid) begin
      s1_ch_q   <= char_in.ch;
      s1_last_q <= char_in.last;
    end
    if (s1_fire && s1_last_q) begin
      out_status_q <= status_d;
    end
  end

endmodule

FILE: hw/rtl/asfc_cfg_regs.sv
// Limit registers of the alert string format checker, written by index.
// Depends on asfc_pkg.
module asfc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [asfc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output asfc_pkg::cfg_t                cfg_o
);

  asfc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (asfc_pkg::cfg_idx_e'(cfg_idx_i))
        asfc_pkg::CfgMaxTextLen:   cfg_d.max_text_len   = cfg_wdata_i[asfc_pkg::LenW-1:0];
        asfc_pkg::CfgMaxTextLines: cfg_d.max_text_lines = cfg_wdata_i[asfc_pkg::CntW-1:0];
        asfc_pkg::CfgMaxButtonLen: cfg_d.max_button_len = cfg_wdata_i[asfc_pkg::LenW-1:0];
        asfc_pkg::CfgMaxButtons:   cfg_d.max_buttons    = cfg_wdata_i[asfc_pkg::CntW-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_text_len   <= asfc_pkg::RstMaxTextLen;
      cfg_q.max_text_lines <= asfc_pkg::RstMaxTextLines;
      cfg_q.max_button_len <= asfc_pkg::RstMaxButtonLen;
      cfg_q.max_buttons    <= asfc_pkg::RstMaxButtons;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/asfc_step.sv
// Per-character next-state and status logic of the alert string format checker.
// Pure combinational; depends on asfc_pkg.
module asfc_step (
  input  asfc_pkg::scan_state_t        state_i,
  input  asfc_pkg::cfg_t               cfg_i,
  input  logic [asfc_pkg::ChW-1:0]     ch_i,
  input  logic                         last_i,
  output asfc_pkg::scan_state_t        state_o,
  output logic [asfc_pkg::StatW-1:0]   status_o
);

  logic                        is_sep;
  logic                        closed;
  logic [asfc_pkg::LenW-1:0]   max_len;
  logic [asfc_pkg::CntW-1:0]   max_cnt;
  logic [asfc_pkg::LenW-1:0]   chars_n;
  logic [asfc_pkg::CntW-1:0]   count_n;
  logic                        any_n;
  logic                        too_long;
  logic                        too_many;
  asfc_pkg::status_e           err;
  asfc_pkg::scan_state_t       nxt;

  assign is_sep  = (ch_i == asfc_pkg::ChSep) || (ch_i == asfc_pkg::ChClose);
  assign closed  = (ch_i == asfc_pkg::ChClose);
  assign max_len = (state_i.phase == asfc_pkg::PhText) ? cfg_i.max_text_len
                                                       : cfg_i.max_button_len;
  assign max_cnt = (state_i.phase == asfc_pkg::PhText) ? cfg_i.max_text_lines
                                                       : cfg_i.max_buttons;

  // shared field counters of both bracketed sections
  always_comb begin
    chars_n  = state_i.field_chars;
    count_n  = state_i.field_count;
    any_n    = state_i.any_chars;
    too_long = 1'b0;
    if (!is_sep) begin
      if (state_i.field_chars != '1) chars_n = state_i.field_chars + 1'b1;
      any_n = 1'b1;
    end else begin
      if (state_i.field_count != '1) count_n = state_i.field_count + 1'b1;
      too_long = (state_i.field_chars > max_len);
      chars_n  = '0;
    end
  end

  assign too_many = is_sep && (count_n > max_cnt);

  always_comb begin
    nxt = state_i;
    err = asfc_pkg::StOk;
    if (!state_i.settled) begin
      unique case (state_i.phase)
        asfc_pkg::PhIcon: begin
          priority if (state_i.icon_pos == 2'd0 && ch_i != asfc_pkg::ChOpen) begin
            nxt.verdict = asfc_pkg::StIcon;
            nxt.settled = 1'b1;
          end else if (state_i.icon_pos == 2'd1 &&
                       (ch_i < asfc_pkg::ChDigLo || ch_i > asfc_pkg::ChDigHi)) begin
            nxt.verdict = asfc_pkg::StIcon;
            nxt.settled = 1'b1;
          end else if (state_i.icon_pos == 2'd2 && ch_i != asfc_pkg::ChClose) begin
            nxt.verdict = asfc_pkg::StIcon;
            nxt.settled = 1'b1;
          end else if (last_i) begin
            nxt.verdict = state_i.icon_pos[1] ? asfc_pkg::StTextOpen : asfc_pkg::StIcon;
            nxt.settled = 1'b1;
          end else if (state_i.icon_pos == 2'd3) begin
            nxt.phase = asfc_pkg::PhText;
          end else begin
            nxt.icon_pos = state_i.icon_pos + 1'b1;
          end
        end
        asfc_pkg::PhText: begin
          nxt.field_chars = chars_n;
          nxt.field_count = count_n;
          nxt.any_chars   = any_n;
          if (too_long) err = asfc_pkg::StTextLong;
          if (too_many) err = asfc_pkg::StTextLines;
          if (last_i)   err = asfc_pkg::StTextOpen;
          if (err != asfc_pkg::StOk || closed) begin
            priority if (!any_n) begin
              nxt.verdict = asfc_pkg::StTextEmpty;
              nxt.settled = 1'b1;
            end else if (err != asfc_pkg::StOk) begin
              nxt.verdict = err;
              nxt.settled = 1'b1;
            end else begin
              nxt.phase       = asfc_pkg::PhBopen;
              nxt.field_chars = '0;
              nxt.field_count = '0;
              nxt.any_chars   = 1'b0;
            end
          end
        end
        asfc_pkg::PhBopen: begin
          priority if (ch_i != asfc_pkg::ChOpen) begin
            nxt.verdict = asfc_pkg::StNoBracket;
            nxt.settled = 1'b1;
          end else if (last_i) begin
            nxt.verdict = asfc_pkg::StButtonsEmpty;
            nxt.settled = 1'b1;
          end else begin
            nxt.phase = asfc_pkg::PhButtons;
          end
        end
        asfc_pkg::PhButtons: begin
          nxt.field_chars = chars_n;
          nxt.field_count = count_n;
          nxt.any_chars   = any_n;
          if (too_long) err = asfc_pkg::StButtonLong;
          if (too_many) err = asfc_pkg::StButtonsMany;
          if (!closed && last_i) err = asfc_pkg::StButtonsOpen;
          if (err != asfc_pkg::StOk || closed) begin
            nxt.verdict = any_n ? err : asfc_pkg::StButtonsEmpty;
            nxt.settled = 1'b1;
          end
        end
        default: nxt = state_i;
      endcase
    end
  end

  assign state_o  = nxt;
  assign status_o = nxt.settled ? nxt.verdict : asfc_pkg::StOk;

endmodule

FILE: hw/rtl/asfc_checker.sv
// Port-level assertions for the alert string format checker, bound to the top level.
// Depends on asfc_pkg and alert_string_format_checker_unit.
module asfc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [asfc_pkg::StatW-1:0] out_status_i
);

  // a stalled status beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("status beat changed while stalled");

  // only defined status codes appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i <= asfc_pkg::StButtonsEmpty))
    else $error("status code out of range");

  // a fresh status beat follows an accepted last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("status beat without a last character");

endmodule

bind alert_string_format_checker_unit asfc_checker u_asfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (char_in.valid),
  .in_ready_i  (char_in.ready),
  .in_last_i   (char_in.last),
  .out_valid_i (status_out.valid),
  .out_ready_i (status_out.ready),
  .out_status_i(status_out.status)
);

FILE: verif/testbench.sv
// Self-checking testbench for alert_string_format_checker_unit: random and directed alert strings.
// Depends on asfc_pkg, the asfc_char_if / asfc_status_if interfaces and the unit's RTL.
// A built-in scan predictor supplies the expected status for every string.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // No-accept cycles before the run is declared hung, and the length of the long hold-off.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 100;
  // Margin after the last status is seen, before the next phase starts.
  localparam int unsigned DrainCycles = 6;

  typedef struct packed {
    logic [asfc_pkg::ChW-1:0] ch;
    logic                     last;
  } char_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                          cfg_we;
  logic [asfc_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [asfc_pkg::CfgDataW-1:0] cfg_wdata;

  asfc_char_if   char_if ();
  asfc_status_if status_if ();

  alert_string_format_checker_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .char_in     (char_if),
    .status_out  (status_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  char_beat_t        char_backlog[$];   // characters waiting to be offered
  asfc_pkg::status_e status_due[$];     // status of each string accepted, oldest first
  int unsigned chars_queued = 0;  // characters put into the backlog
  int unsigned chars_taken  = 0;  // characters the unit has accepted
  int unsigned mismatches   = 0;

  int unsigned tx_gap_max   = 7;  // idle cycles drawn after each char beat
  int unsigned rx_stall_max = 7;  // not-ready cycles drawn after each status beat
  int unsigned hold_reqs    = 0;  // bumped by the sequencer to ask for a long hold-off

  // ---------------------------------------------------------------------------
  // Scan predictor: limits and per-string state, mirrors what the unit tracks
  // ---------------------------------------------------------------------------
  asfc_pkg::cfg_t limits = '{
    max_text_len:   asfc_pkg::RstMaxTextLen,
    max_text_lines: asfc_pkg::RstMaxTextLines,
    max_button_len: asfc_pkg::RstMaxButtonLen,
    max_buttons:    asfc_pkg::RstMaxButtons
  };
  asfc_pkg::scan_state_t scan = asfc_pkg::ScanReset;

  function automatic void settle_scan(input asfc_pkg::status_e code);
    scan.verdict = code;
    scan.settled = 1'b1;
  endfunction

  // One character inside a bracketed section. A separator or closer ends a
  // field; the count check runs after the length check so it wins.
  function automatic void count_field_char(input logic [asfc_pkg::ChW-1:0] c,
                                           input logic [asfc_pkg::LenW-1:0] max_len,
                                           input logic [asfc_pkg::CntW-1:0] max_cnt,
                                           input asfc_pkg::status_e code_long,
                                           input asfc_pkg::status_e code_many,
                                           output asfc_pkg::status_e err,
                                           output logic closed);
    err = asfc_pkg::StOk;
    closed = 1'b0;
    if (c != asfc_pkg::ChSep && c != asfc_pkg::ChClose) begin
      if (scan.field_chars != '1) scan.field_chars = scan.field_chars + 1'b1;
      scan.any_chars = 1'b1;
    end else begin
      if (scan.field_count != '1) scan.field_count = scan.field_count + 1'b1;
      if (scan.field_chars > max_len) err = code_long;
      if (c == asfc_pkg::ChClose) closed = 1'b1;
      if (scan.field_count > max_cnt) err = code_many;
      scan.field_chars = '0;
    end
  endfunction

  // Advance the predictor by one accepted character; a last beat yields a status.
  function automatic void scan_char(input logic [asfc_pkg::ChW-1:0] c, input logic is_last,
                                    output logic emits, output asfc_pkg::status_e verdict_out);
    asfc_pkg::status_e err;
    logic              closed;
    emits = is_last;
    verdict_out = asfc_pkg::StOk;
    if (!scan.settled) begin
      case (scan.phase)
        asfc_pkg::PhIcon: begin
          if (scan.icon_pos == 2'd0 && c != asfc_pkg::ChOpen) settle_scan(asfc_pkg::StIcon);
          else if (scan.icon_pos == 2'd1 &&
                   (c < asfc_pkg::ChDigLo || c > asfc_pkg::ChDigHi))
            settle_scan(asfc_pkg::StIcon);
          else if (scan.icon_pos == 2'd2 && c != asfc_pkg::ChClose)
            settle_scan(asfc_pkg::StIcon);
          else if (is_last)
            settle_scan(scan.icon_pos < 2'd2 ? asfc_pkg::StIcon : asfc_pkg::StTextOpen);
          else if (scan.icon_pos == 2'd3) scan.phase = asfc_pkg::PhText;  // skipped char
          else scan.icon_pos = scan.icon_pos + 2'd1;
        end
        asfc_pkg::PhText: begin
          count_field_char(c, limits.max_text_len, limits.max_text_lines,
                           asfc_pkg::StTextLong, asfc_pkg::StTextLines, err, closed);
          if (is_last) err = asfc_pkg::StTextOpen;
          if (err != asfc_pkg::StOk || closed) begin
            // an empty section beats every other text code
            if (!scan.any_chars) settle_scan(asfc_pkg::StTextEmpty);
            else if (err != asfc_pkg::StOk) settle_scan(err);
            else begin
              scan.phase       = asfc_pkg::PhBopen;
              scan.field_chars = '0;
              scan.field_count = '0;
              scan.any_chars   = 1'b0;
            end
          end
        end
        asfc_pkg::PhBopen: begin
          if (c != asfc_pkg::ChOpen) settle_scan(asfc_pkg::StNoBracket);
          else if (is_last) settle_scan(asfc_pkg::StButtonsEmpty);
          else scan.phase = asfc_pkg::PhButtons;
        end
        default: begin
          count_field_char(c, limits.max_button_len, limits.max_buttons,
                           asfc_pkg::StButtonLong, asfc_pkg::StButtonsMany, err, closed);
          if (!closed && is_last) err = asfc_pkg::StButtonsOpen;
          if (err != asfc_pkg::StOk || closed) begin
            if (!scan.any_chars) settle_scan(asfc_pkg::StButtonsEmpty);
            else settle_scan(err);  // clean close settles as ok
          end
        end
      endcase
    end
    if (is_last) begin
      verdict_out = scan.settled ? scan.verdict : asfc_pkg::StOk;
      scan = asfc_pkg::ScanReset;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver: offers backlog beats, random gap after each accepted beat
  // ---------------------------------------------------------------------------
  int unsigned tx_gap = 0;

  always @(posedge clk_i) begin : char_driver
    char_beat_t        nxt;
    logic              emits;
    asfc_pkg::status_e st;
    if (rst_ni) begin
      if (char_if.valid && char_if.ready) begin
        scan_char(char_if.ch, char_if.last, emits, st);
        if (emits) status_due.push_back(st);
        chars_taken++;
        tx_gap = $urandom_range(0, tx_gap_max);
      end
      if (char_if.valid && !char_if.ready) begin
        // beat still offered, hold it
      end else if (tx_gap != 0) begin
        tx_gap--;
        char_if.valid <= 1'b0;
      end else if (char_backlog.size() == 0) begin
        char_if.valid <= 1'b0;
      end else begin
        nxt = char_backlog.pop_front();
        char_if.valid <= 1'b1;
        char_if.ch    <= nxt.ch;
        char_if.last  <= nxt.last;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Status monitor and ready driver: checks each beat against the oldest
  // prediction, stalls at random, and serves long hold-off requests
  // ---------------------------------------------------------------------------
  int unsigned rx_stall  = 0;
  int unsigned rx_hold   = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk_i) begin : status_monitor
    asfc_pkg::status_e want;
    if (rst_ni) begin
      if (status_if.valid && status_if.ready) begin
        if (status_due.size() == 0) begin
          $error("status: beat with no string pending, expected none, actual %0d",
                 status_if.status);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          if (status_if.status !== want) begin
            $error("status: expected %0d, actual %0d", want, status_if.status);
            mismatches++;
          end
        end
        rx_stall = $urandom_range(0, rx_stall_max);
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        rx_hold   = HoldCycles;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        status_if.ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        status_if.ready <= 1'b0;
      end else begin
        status_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any beat on either side means a hang.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((char_if.valid && char_if.ready) || (status_if.valid && status_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_bytes(input logic [asfc_pkg::ChW-1:0] s[$]);
    char_beat_t b;
    foreach (s[i]) begin
      b.ch   = s[i];
      b.last = (i == s.size() - 1);
      char_backlog.push_back(b);
      chars_queued++;
    end
  endtask

  // Bracketed section body: fields split by '|', closed by ']'. Sizes sit
  // mostly low, sometimes right at the limits to hit long / many codes.
  task automatic add_section(ref logic [asfc_pkg::ChW-1:0] s[$], input int max_len,
                             input int max_cnt);
    int n_fields;
    int flen;
    logic [asfc_pkg::ChW-1:0] b;
    if ($urandom_range(0, 3) == 0) n_fields = max_cnt + int'($urandom_range(0, 1));
    else n_fields = int'($urandom_range(1, 3));
    if (n_fields < 1) n_fields = 1;
    for (int f = 0; f < n_fields; f++) begin
      if ($urandom_range(0, 3) == 0) flen = max_len - 1 + int'($urandom_range(0, 2));
      else flen = int'($urandom_range(0, 4));
      if (flen < 0) flen = 0;
      if (f != 0) s.push_back(asfc_pkg::ChSep);
      repeat (flen) begin
        do b = 8'($urandom_range(0, 255));
        while (b == asfc_pkg::ChSep || b == asfc_pkg::ChClose);
        s.push_back(b);
      end
    end
    s.push_back(asfc_pkg::ChClose);
  endtask

  // One alert string: well formed most of the time, otherwise with a byte
  // corrupted, cut short, or followed by junk after the verdict.
  task automatic queue_alert();
    logic [asfc_pkg::ChW-1:0] s[$];
    int cut;
    s.push_back(asfc_pkg::ChOpen);
    s.push_back(asfc_pkg::ChDigLo + 8'($urandom_range(0, 3)));
    s.push_back(asfc_pkg::ChClose);
    s.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : asfc_pkg::ChOpen);
    add_section(s, int'(limits.max_text_len), int'(limits.max_text_lines));
    s.push_back(asfc_pkg::ChOpen);
    add_section(s, int'(limits.max_button_len), int'(limits.max_buttons));
    case ($urandom_range(0, 9))
      0: s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        cut = $urandom_range(1, s.size());
        while (s.size() > cut) void'(s.pop_back());
      end
      2: repeat ($urandom_range(1, 5)) s.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    queue_bytes(s);
  endtask

  task automatic write_limit(input asfc_pkg::cfg_idx_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[asfc_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Only called with the unit idle; predictor limits follow the writes.
  task automatic apply_limits(input int unsigned tl, input int unsigned tn,
                              input int unsigned bl, input int unsigned bn);
    write_limit(asfc_pkg::CfgMaxTextLen, tl);
    write_limit(asfc_pkg::CfgMaxTextLines, tn);
    write_limit(asfc_pkg::CfgMaxButtonLen, bl);
    write_limit(asfc_pkg::CfgMaxButtons, bn);
    limits.max_text_len   = tl[asfc_pkg::LenW-1:0];
    limits.max_text_lines = tn[asfc_pkg::CntW-1:0];
    limits.max_button_len = bl[asfc_pkg::LenW-1:0];
    limits.max_buttons    = bn[asfc_pkg::CntW-1:0];
  endtask

  // Every queued char accepted and every status seen, then let the pipe empty.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (chars_taken != chars_queued || status_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int unsigned budget;
    int unsigned target;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    char_if.valid   = 1'b0;
    char_if.ch      = '0;
    char_if.last    = 1'b0;
    status_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings on reset limits: header cut after the opener, closer and
    // skipped char, bad first byte and digit, text closer as final char (with and
    // without text), zero byte as skipped char and as text, bare button bracket.
    queue_bytes('{8'hFF});
    queue_bytes('{asfc_pkg::ChOpen});
    queue_bytes('{asfc_pkg::ChOpen, "4"});
    queue_bytes('{asfc_pkg::ChOpen, "3", asfc_pkg::ChClose});
    queue_bytes('{asfc_pkg::ChOpen, asfc_pkg::ChDigLo, asfc_pkg::ChClose, 8'h00});
    queue_bytes('{asfc_pkg::ChOpen, "1", asfc_pkg::ChClose, asfc_pkg::ChOpen,
                  asfc_pkg::ChClose});
    queue_bytes('{asfc_pkg::ChOpen, "2", asfc_pkg::ChClose, asfc_pkg::ChOpen, 8'h00,
                  asfc_pkg::ChClose});
    queue_bytes('{asfc_pkg::ChOpen, asfc_pkg::ChDigHi, asfc_pkg::ChClose, asfc_pkg::ChOpen,
                  "a", asfc_pkg::ChClose, asfc_pkg::ChOpen});

    for (int p = 0; p <= 7; p++) begin
      wait_drained();
      case (p)
        0: budget = 150;  // reset limits, full idling
        1: begin  // smallest limits
          apply_limits(0, 1, 0, 1);
          budget = 150;
        end
        2: begin  // largest in-range limits, back-to-back traffic
          apply_limits(62, 6, 62, 6);
          tx_gap_max = 0;
          rx_stall_max = 0;
          budget = 250;
        end
        3: begin  // saturating counters never trip these
          apply_limits(63, 7, 63, 7);
          tx_gap_max = 3;
          rx_stall_max = 7;
          budget = 200;
        end
        4: begin  // zero counts: first separator already too many
          apply_limits(4, 0, 3, 0);
          tx_gap_max = 7;
          rx_stall_max = 0;
          budget = 100;
        end
        5: begin  // pressure: sender flat out while the receiver holds off
          apply_limits($urandom_range(0, 12), $urandom_range(1, 6),
                       $urandom_range(0, 12), $urandom_range(1, 6));
          tx_gap_max = 0;
          rx_stall_max = 0;
          budget = 200;
        end
        6: begin
          apply_limits($urandom_range(0, 63), $urandom_range(0, 7),
                       $urandom_range(0, 63), $urandom_range(0, 7));
          tx_gap_max = 7;
          rx_stall_max = 7;
          budget = 150;
        end
        default: begin  // back to reset values
          apply_limits(32'(asfc_pkg::RstMaxTextLen), 32'(asfc_pkg::RstMaxTextLines),
                       32'(asfc_pkg::RstMaxButtonLen), 32'(asfc_pkg::RstMaxButtons));
          tx_gap_max = 0;
          rx_stall_max = 7;
          budget = 100;
        end
      endcase
      target = chars_queued + budget;
      while (chars_queued < target) queue_alert();
      if (p == 5) hold_reqs++;
    end

    wait_drained();
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
